FILE: src/butterworth_lowpass_spectrum_mask_core_assert.svh
// Assertion macros for the Butterworth spectrum mask core and its checker.
// No dependencies; included by the checker file.
`ifndef BUTTERWORTH_LOWPASS_SPECTRUM_MASK_CORE_ASSERT_SVH
`define BUTTERWORTH_LOWPASS_SPECTRUM_MASK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define BLSM_ASSERT_IMP(lbl, a_clk, a_rstn, ante, cons, msg) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BLSM_ASSERT_NXT(lbl, a_clk, a_rstn, ante, cons, msg) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/blsm_pkg.sv
// Shared types and constants for the Butterworth spectrum mask core.
// No dependencies; used by the core and its checker.
package blsm_pkg;

    localparam int DIM_W      = 13;
    localparam int IDX_W      = 12;
    localparam int CUT_W      = 12;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 17;
    localparam int MAX_DIM    = 4096;
    localparam int Q_ONE      = 65536;
    localparam int FRAC_BITS  = 16;

    localparam int OFS_W      = 14;   // wrapped offset, signed
    localparam int SQ_W       = 24;   // offset squared
    localparam int D2_W       = 25;
    localparam int D2SQ_W     = 50;
    localparam int K4_W       = 48;
    localparam int DEN_W      = 51;

    // Pipeline layout: five arithmetic stages, one divider stage per quotient
    // bit, then the scaling stage which is also the result register.
    localparam int DIV_STEPS  = GAIN_W;
    localparam int STG_DIV0   = 5;
    localparam int STG_OUT    = STG_DIV0 + DIV_STEPS;
    localparam int NUM_STG    = STG_OUT + 1;

    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_HEIGHT = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [DATA_W-1:0] real_in;
        logic signed [DATA_W-1:0] imag_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] real_out;
        logic signed [DATA_W-1:0] imag_out;
        logic [GAIN_W-1:0]        gain;
    } out_item_t;

endpackage

FILE: src/butterworth_lowpass_spectrum_mask_core.sv
// Order-2 Butterworth low-pass mask over an unshifted spectrum, one bin per
// cycle while the output side does not stall. Depends on blsm_pkg.
//
// Each bin gets gain H = c^4 / (c^4 + d2^2) in Q1.16, with d2 the squared
// distance to the nearest spectrum corner; both parts are scaled by H and
// shifted right by 16 (floor). The block takes one bin every cycle while the
// output side does not stall and passes it through 23 register stages: five
// for the offsets, squares, squared distance, fourth powers and denominator,
// seventeen of a pipelined restoring divider (one quotient bit each), and one
// scaling stage that is also the result register. Stalls collapse bubbles
// stage by stage.
// Configuration writes are taken every cycle; write them only while the
// pipeline is empty. Dimensions above 4096 are held as 4096.
module butterworth_lowpass_spectrum_mask_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 item_valid,
    output logic                                 item_ready,
    input  blsm_pkg::in_item_t                   item,

    output logic                                 result_valid,
    input  logic                                 result_ready,
    output blsm_pkg::out_item_t                  result,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [blsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [blsm_pkg::DIM_W-1:0]           cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [blsm_pkg::CUT_W-1:0] cutoff_reg;
    logic [blsm_pkg::DIM_W-1:0] width_reg;
    logic [blsm_pkg::DIM_W-1:0] height_reg;
    logic [blsm_pkg::DIM_W-1:0] dim_clamped;

    assign cfg_ready   = 1'b1;
    assign dim_clamped = (cfg_data > blsm_pkg::DIM_W'(blsm_pkg::MAX_DIM))
                         ? blsm_pkg::DIM_W'(blsm_pkg::MAX_DIM) : cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cutoff_reg <= blsm_pkg::CUT_W'(30);
            width_reg  <= blsm_pkg::DIM_W'(512);
            height_reg <= blsm_pkg::DIM_W'(512);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                blsm_pkg::CFG_CUTOFF: cutoff_reg <= cfg_data[blsm_pkg::CUT_W-1:0];
                blsm_pkg::CFG_WIDTH:  width_reg  <= dim_clamped;
                blsm_pkg::CFG_HEIGHT: height_reg <= dim_clamped;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage valids and per-stage enables
    // ------------------------------------------------------------------
    logic [blsm_pkg::NUM_STG-1:0] vld_reg;
    logic [blsm_pkg::NUM_STG-1:0] en;

    // A stage loads when it is empty or its content moves on.
    always_comb
    begin
        en[blsm_pkg::STG_OUT] = !vld_reg[blsm_pkg::STG_OUT] || result_ready;
        for (int i = blsm_pkg::STG_OUT - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign item_ready   = en[0];
    assign result_valid = vld_reg[blsm_pkg::STG_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= item_valid;
            end
            for (int i = 1; i < blsm_pkg::NUM_STG; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: wrapped offsets to the nearest corner
    // ------------------------------------------------------------------
    logic signed [blsm_pkg::OFS_W-1:0]  s0_dy_next, s0_dx_next;
    logic signed [blsm_pkg::OFS_W-1:0]  s0_dy_reg, s0_dx_reg;
    logic [blsm_pkg::CUT_W-1:0]         s0_k_reg;
    logic signed [blsm_pkg::DATA_W-1:0] s0_re_reg, s0_im_reg;
    logic                               row_wrap, col_wrap;

    assign row_wrap = item.row > height_reg[blsm_pkg::DIM_W-1:1];
    assign col_wrap = item.col > width_reg[blsm_pkg::DIM_W-1:1];

    assign s0_dy_next = row_wrap
        ? $signed({1'b0, height_reg}) - $signed({2'b00, item.row})
        : $signed({2'b00, item.row});
    assign s0_dx_next = col_wrap
        ? $signed({1'b0, width_reg}) - $signed({2'b00, item.col})
        : $signed({2'b00, item.col});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_dy_reg <= s0_dy_next;
            s0_dx_reg <= s0_dx_next;
            s0_k_reg  <= cutoff_reg;
            s0_re_reg <= item.real_in;
            s0_im_reg <= item.imag_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares
    // ------------------------------------------------------------------
    logic signed [2*blsm_pkg::OFS_W-1:0] dy_sq, dx_sq;
    logic [blsm_pkg::SQ_W-1:0]           s1_dy2_reg, s1_dx2_reg, s1_k2_reg;
    logic signed [blsm_pkg::DATA_W-1:0]  s1_re_reg, s1_im_reg;

    assign dy_sq = (2*blsm_pkg::OFS_W)'(s0_dy_reg) * (2*blsm_pkg::OFS_W)'(s0_dy_reg);
    assign dx_sq = (2*blsm_pkg::OFS_W)'(s0_dx_reg) * (2*blsm_pkg::OFS_W)'(s0_dx_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_dy2_reg <= dy_sq[blsm_pkg::SQ_W-1:0];
            s1_dx2_reg <= dx_sq[blsm_pkg::SQ_W-1:0];
            s1_k2_reg  <= blsm_pkg::SQ_W'(s0_k_reg) * blsm_pkg::SQ_W'(s0_k_reg);
            s1_re_reg  <= s0_re_reg;
            s1_im_reg  <= s0_im_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared distance
    // ------------------------------------------------------------------
    logic [blsm_pkg::D2_W-1:0]          s2_d2_reg;
    logic [blsm_pkg::SQ_W-1:0]          s2_k2_reg;
    logic signed [blsm_pkg::DATA_W-1:0] s2_re_reg, s2_im_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_d2_reg <= {1'b0, s1_dy2_reg} + {1'b0, s1_dx2_reg};
            s2_k2_reg <= s1_k2_reg;
            s2_re_reg <= s1_re_reg;
            s2_im_reg <= s1_im_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: fourth powers
    // ------------------------------------------------------------------
    logic [blsm_pkg::D2SQ_W-1:0]        s3_d2sq_reg;
    logic [blsm_pkg::K4_W-1:0]          s3_k4_reg;
    logic signed [blsm_pkg::DATA_W-1:0] s3_re_reg, s3_im_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_d2sq_reg <= blsm_pkg::D2SQ_W'(s2_d2_reg) * blsm_pkg::D2SQ_W'(s2_d2_reg);
            s3_k4_reg   <= blsm_pkg::K4_W'(s2_k2_reg) * blsm_pkg::K4_W'(s2_k2_reg);
            s3_re_reg   <= s2_re_reg;
            s3_im_reg   <= s2_im_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: denominator
    // ------------------------------------------------------------------
    logic [blsm_pkg::DEN_W-1:0]         s4_den_next;
    logic [blsm_pkg::DEN_W-1:0]         s4_den_reg;
    logic [blsm_pkg::K4_W-1:0]          s4_k4_reg;
    logic                               s4_dz_reg;
    logic signed [blsm_pkg::DATA_W-1:0] s4_re_reg, s4_im_reg;

    assign s4_den_next = {3'b000, s3_k4_reg} + {1'b0, s3_d2sq_reg};

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_den_reg <= s4_den_next;
            s4_dz_reg  <= (s4_den_next == '0);
            s4_k4_reg  <= s3_k4_reg;
            s4_re_reg  <= s3_re_reg;
            s4_im_reg  <= s3_im_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, most significant first.
    // The first step compares k4 itself; later steps double the remainder.
    // ------------------------------------------------------------------
    logic [blsm_pkg::DEN_W-1:0]         dv_rem_reg [blsm_pkg::DIV_STEPS];
    logic [blsm_pkg::DEN_W-1:0]         dv_den_reg [blsm_pkg::DIV_STEPS];
    logic [blsm_pkg::GAIN_W-1:0]        dv_q_reg   [blsm_pkg::DIV_STEPS];
    logic                               dv_dz_reg  [blsm_pkg::DIV_STEPS];
    logic signed [blsm_pkg::DATA_W-1:0] dv_re_reg  [blsm_pkg::DIV_STEPS];
    logic signed [blsm_pkg::DATA_W-1:0] dv_im_reg  [blsm_pkg::DIV_STEPS];

    for (genvar j = 0; j < blsm_pkg::DIV_STEPS; j++)
    begin : g_div
        logic [blsm_pkg::DEN_W-1:0]         rem_in, den_in;
        logic [blsm_pkg::GAIN_W-1:0]        q_in;
        logic                               dz_in;
        logic signed [blsm_pkg::DATA_W-1:0] re_in, im_in;
        logic [blsm_pkg::DEN_W:0]           trial, diff;
        logic                               take;

        if (j == 0)
        begin : g_first
            assign rem_in = {3'b000, s4_k4_reg};
            assign den_in = s4_den_reg;
            assign q_in   = '0;
            assign dz_in  = s4_dz_reg;
            assign re_in  = s4_re_reg;
            assign im_in  = s4_im_reg;
            assign trial  = {1'b0, rem_in};
        end
        else
        begin : g_rest
            assign rem_in = dv_rem_reg[j-1];
            assign den_in = dv_den_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign dz_in  = dv_dz_reg[j-1];
            assign re_in  = dv_re_reg[j-1];
            assign im_in  = dv_im_reg[j-1];
            assign trial  = {rem_in, 1'b0};
        end

        assign take = trial >= {1'b0, den_in};
        assign diff = trial - {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en[blsm_pkg::STG_DIV0 + j])
            begin
                dv_rem_reg[j] <= take ? diff[blsm_pkg::DEN_W-1:0]
                                      : trial[blsm_pkg::DEN_W-1:0];
                dv_den_reg[j] <= den_in;
                dv_q_reg[j]   <= q_in | (blsm_pkg::GAIN_W'(take)
                                         << (blsm_pkg::DIV_STEPS - 1 - j));
                dv_dz_reg[j]  <= dz_in;
                dv_re_reg[j]  <= re_in;
                dv_im_reg[j]  <= im_in;
            end
        end
    end

    // ------------------------------------------------------------------
    // Scaling stage and result register
    // ------------------------------------------------------------------
    localparam int LAST = blsm_pkg::DIV_STEPS - 1;
    localparam int PROD_W = blsm_pkg::DATA_W + blsm_pkg::GAIN_W + 1;

    logic [blsm_pkg::GAIN_W-1:0] gain_next;
    logic signed [PROD_W-1:0]    prod_re, prod_im;
    blsm_pkg::out_item_t         result_reg;

    // Zero denominator only happens at DC with zero cutoff: gain is zero there.
    assign gain_next = dv_dz_reg[LAST] ? '0 : dv_q_reg[LAST];
    assign prod_re   = PROD_W'(dv_re_reg[LAST]) * PROD_W'($signed({1'b0, gain_next}));
    assign prod_im   = PROD_W'(dv_im_reg[LAST]) * PROD_W'($signed({1'b0, gain_next}));

    always_ff @(posedge clk)
    begin
        if (en[blsm_pkg::STG_OUT])
        begin
            result_reg.real_out <= prod_re[blsm_pkg::FRAC_BITS +: blsm_pkg::DATA_W];
            result_reg.imag_out <= prod_im[blsm_pkg::FRAC_BITS +: blsm_pkg::DATA_W];
            result_reg.gain     <= gain_next;
        end
    end

    assign result = result_reg;

endmodule

FILE: src/blsm_checker.sv
// Port-level checks for the Butterworth spectrum mask core, bound to the top.
// Depends on blsm_pkg and butterworth_lowpass_spectrum_mask_core_assert.svh.
`include "butterworth_lowpass_spectrum_mask_core_assert.svh"

module blsm_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           result_valid,
    input logic                           result_ready,
    input blsm_pkg::out_item_t            result,
    input logic                           cfg_valid,
    input logic                           cfg_ready
);

    // A result that is not taken stays offered.
    `BLSM_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
                     result_valid, "result dropped while stalled")

    // Gain never exceeds one.
    `BLSM_ASSERT_IMP(a_gain_max, clk, rst_n, result_valid,
                     result.gain <= blsm_pkg::GAIN_W'(blsm_pkg::Q_ONE), "gain above one")

    // Zero gain scales both parts to exactly zero.
    `BLSM_ASSERT_IMP(a_zero_gain, clk, rst_n, result_valid && (result.gain == '0),
                     (result.real_out == '0) && (result.imag_out == '0),
                     "nonzero output at zero gain")

    // Register writes are never held off.
    `BLSM_ASSERT_IMP(a_cfg_open, clk, rst_n, cfg_valid, cfg_ready,
                     "configuration write stalled")

endmodule

bind butterworth_lowpass_spectrum_mask_core blsm_checker u_blsm_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
